@@ design/assert_macros.svh @@
// Assertion helpers. Both sample on clk and are switched off while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every sampled edge.
`define GHT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// A trigger implies a consequence in the cycle after it.
`define GHT_ASSERT_NEXT(lbl, trig, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cons)) \
		else $error(msg);

`endif

@@ design/ght_pkg.sv @@
package ght_pkg;

	localparam int NUM_SLOTS_DEF = 64;
	localparam int HANDLE_W      = 32;
	localparam int TAG_W         = 16;
	localparam int GEN_W         = 16;
	localparam int DIRECT_W      = 16;
	localparam int SLOT_OUT_W    = 6;
	localparam int LIVE_W        = 7;
	localparam logic [GEN_W-1:0] GEN_RESET = 16'd1;

	typedef enum logic [2:0] {
		REQ_ALLOC    = 3'd0,
		REQ_REGISTER = 3'd1,
		REQ_LOOKUP   = 3'd2,
		REQ_FREE     = 3'd3,
		REQ_CLEAR    = 3'd4
	} req_code_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_FULL = 2'd1,
		ST_MISS = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SWEEP,
		S_DONE,
		S_OUT
	} state_t;

	// Update broadcast to all cells; the slot select comes separately.
	typedef struct packed {
		logic                wr;
		logic                clr_one;
		logic                clr_all;
		logic [HANDLE_W-1:0] handle;
		logic [TAG_W-1:0]    tag;
	} wr_t;

endpackage

@@ design/ght_req_if.sv @@
interface ght_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  req_type;
	logic [31:0] net_id;
	logic [15:0] object_tag;

	modport source (output valid, req_type, net_id, object_tag, input ready);
	modport sink   (input valid, req_type, net_id, object_tag, output ready);
endinterface

@@ design/ght_rsp_if.sv @@
interface ght_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] handle_out;
	logic [5:0]  slot_out;
	logic [15:0] tag_out;
	logic [1:0]  status;
	logic [6:0]  live_count;

	modport source (output valid, handle_out, slot_out, tag_out, status, live_count,
		input ready);
	modport sink   (input valid, handle_out, slot_out, tag_out, status, live_count,
		output ready);
endinterface

@@ design/generational_handle_table.sv @@
// Generational handle table.
// Requests arrive on req (valid/ready): req_type, net_id, object_tag. Each
// request yields exactly one response on rsp (valid/ready): handle_out,
// slot_out, tag_out, status and live_count.
// The slots sit in a row of cells. A request is held in registers and a search
// carry walks down the row, one cell per cycle, picking up the lowest free
// slot, the lowest matching slot and a hit on the slot named by the handle's
// low 16 bits. At the end of the row the result is formed and the chosen slot
// is written or emptied, or all slots are emptied, by a broadcast to the cells.
// From acceptance the request passes the sweep down the cell row, the S_DONE
// state and the response register before rsp.valid. One request is in flight
// at a time; the next is taken the cycle after the response is taken.
// Reset empties the table, zeroes the live count and sets the generation to 1.
// Handle and tag storage is not cleared. While rsp is stalled the response is
// held steady in its output register and req stays not ready.
`include "assert_macros.svh"

module generational_handle_table #(
	parameter int NUM_SLOTS = ght_pkg::NUM_SLOTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	ght_req_if.sink     req,
	ght_rsp_if.source   rsp
);

	localparam int IW = $clog2(NUM_SLOTS);
	localparam int CW = $clog2(NUM_SLOTS + 1);

	ght_pkg::state_t              state_q, state_d;
	logic [IW-1:0]                cnt_q;
	ght_pkg::req_code_t           op_q;
	logic [ght_pkg::HANDLE_W-1:0] id_q;
	logic [ght_pkg::TAG_W-1:0]    tag_q;
	logic [ght_pkg::GEN_W-1:0]    gen_q, gen_d;
	logic [CW-1:0]                count_q, count_d;

	// response register
	logic [ght_pkg::HANDLE_W-1:0] rsp_handle_q;
	logic [ght_pkg::SLOT_OUT_W-1:0] rsp_slot_q;
	logic [ght_pkg::TAG_W-1:0]    rsp_tag_q;
	ght_pkg::status_t             rsp_status_q;

	// search carry between cells; entry 0 is the empty carry fed to slot 0
	logic                         c_free      [NUM_SLOTS+1];
	logic [IW-1:0]                c_free_slot [NUM_SLOTS+1];
	logic                         c_match     [NUM_SLOTS+1];
	logic [IW-1:0]                c_match_slot[NUM_SLOTS+1];
	logic [ght_pkg::TAG_W-1:0]    c_match_tag [NUM_SLOTS+1];
	logic                         c_dir       [NUM_SLOTS+1];
	logic [ght_pkg::TAG_W-1:0]    c_dir_tag   [NUM_SLOTS+1];

	ght_pkg::wr_t                 cmd;
	logic [IW-1:0]                cmd_slot;

	logic [ght_pkg::HANDLE_W-1:0] res_handle;
	logic [IW-1:0]                res_slot;
	logic [ght_pkg::TAG_W-1:0]    res_tag;
	ght_pkg::status_t             res_status;

	assign c_free[0]       = 1'b0;
	assign c_free_slot[0]  = '0;
	assign c_match[0]      = 1'b0;
	assign c_match_slot[0] = '0;
	assign c_match_tag[0]  = '0;
	assign c_dir[0]        = 1'b0;
	assign c_dir_tag[0]    = '0;

	for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cell
		ght_cell #(
			.IW  (IW),
			.IDX (i)
		) u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.id           (id_q),
			.cmd          (cmd),
			.sel          (cmd_slot == IW'(i)),
			.free_i       (c_free[i]),
			.free_slot_i  (c_free_slot[i]),
			.match_i      (c_match[i]),
			.match_slot_i (c_match_slot[i]),
			.match_tag_i  (c_match_tag[i]),
			.dir_i        (c_dir[i]),
			.dir_tag_i    (c_dir_tag[i]),
			.free_o       (c_free[i+1]),
			.free_slot_o  (c_free_slot[i+1]),
			.match_o      (c_match[i+1]),
			.match_slot_o (c_match_slot[i+1]),
			.match_tag_o  (c_match_tag[i+1]),
			.dir_o        (c_dir[i+1]),
			.dir_tag_o    (c_dir_tag[i+1])
		);
	end

	assign req.ready      = (state_q == ght_pkg::S_IDLE);
	assign rsp.valid      = (state_q == ght_pkg::S_OUT);
	assign rsp.handle_out = rsp_handle_q;
	assign rsp.slot_out   = rsp_slot_q;
	assign rsp.tag_out    = rsp_tag_q;
	assign rsp.status     = rsp_status_q;
	assign rsp.live_count = ght_pkg::LIVE_W'(count_q);

	// Next state, result forming and the table update at the end of the walk.
	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		cmd_slot   = '0;
		res_handle = '0;
		res_slot   = '0;
		res_tag    = '0;
		res_status = ght_pkg::ST_OK;
		count_d    = count_q;
		gen_d      = gen_q;
		unique case (state_q)
			ght_pkg::S_IDLE: begin
				if (req.valid) begin
					state_d = ght_pkg::S_SWEEP;
				end
			end
			ght_pkg::S_SWEEP: begin
				if (cnt_q == IW'(NUM_SLOTS - 1)) begin
					state_d = ght_pkg::S_DONE;
				end
			end
			ght_pkg::S_DONE: begin
				state_d = ght_pkg::S_OUT;
				unique case (op_q) inside
					ght_pkg::REQ_ALLOC, ght_pkg::REQ_REGISTER: begin
						if (c_free[NUM_SLOTS]) begin
							res_slot = c_free_slot[NUM_SLOTS];
							res_tag  = tag_q;
							if (op_q == ght_pkg::REQ_ALLOC) begin
								res_handle = {gen_q, ght_pkg::DIRECT_W'(res_slot)};
								gen_d      = gen_q + 1'b1;
							end else begin
								res_handle = id_q;
							end
							cmd.wr     = 1'b1;
							cmd.handle = res_handle;
							cmd.tag    = tag_q;
							cmd_slot   = res_slot;
							count_d    = count_q + 1'b1;
						end else begin
							res_status = ght_pkg::ST_FULL;
						end
					end
					ght_pkg::REQ_LOOKUP, ght_pkg::REQ_FREE: begin
						if (c_dir[NUM_SLOTS] || c_match[NUM_SLOTS]) begin
							// the slot named by the handle wins over the lowest match
							res_handle = id_q;
							if (c_dir[NUM_SLOTS]) begin
								res_slot = id_q[IW-1:0];
								res_tag  = c_dir_tag[NUM_SLOTS];
							end else begin
								res_slot = c_match_slot[NUM_SLOTS];
								res_tag  = c_match_tag[NUM_SLOTS];
							end
							if (op_q == ght_pkg::REQ_FREE) begin
								cmd.clr_one = 1'b1;
								cmd_slot    = res_slot;
								if (count_q != '0) begin
									count_d = count_q - 1'b1;
								end
							end
						end else begin
							res_status = ght_pkg::ST_MISS;
						end
					end
					ght_pkg::REQ_CLEAR: begin
						cmd.clr_all = 1'b1;
						count_d     = '0;
					end
					default: begin
						// unused codes: no change, empty response
					end
				endcase
			end
			ght_pkg::S_OUT: begin
				if (rsp.ready) begin
					state_d = ght_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = ght_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ght_pkg::S_IDLE;
			cnt_q   <= '0;
			count_q <= '0;
			gen_q   <= ght_pkg::GEN_RESET;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			gen_q   <= gen_d;
			if (state_q == ght_pkg::S_SWEEP) begin
				cnt_q <= cnt_q + 1'b1;
			end else begin
				cnt_q <= '0;
			end
		end
	end

	// Request hold and response register: payload only.
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			op_q  <= ght_pkg::req_code_t'(req.req_type);
			id_q  <= req.net_id;
			tag_q <= req.object_tag;
		end
		if (state_q == ght_pkg::S_DONE) begin
			rsp_handle_q <= res_handle;
			rsp_slot_q   <= ght_pkg::SLOT_OUT_W'(res_slot);
			rsp_tag_q    <= res_tag;
			rsp_status_q <= res_status;
		end
	end

	`GHT_ASSERT(a_count_bound, count_q <= CW'(NUM_SLOTS), "live count above table size")
	`GHT_ASSERT(a_full_means_full, !(rsp.valid && rsp_status_q == ght_pkg::ST_FULL) || count_q == CW'(NUM_SLOTS), "full reported on a table with room")
	`GHT_ASSERT_NEXT(a_one_in_flight, req.valid && req.ready, !req.ready && !rsp.valid, "second request taken while one is in flight")
	`GHT_ASSERT_NEXT(a_rsp_release, rsp.valid && rsp.ready, req.ready && !rsp.valid, "table not idle after response taken")

endmodule

@@ design/ght_cell.sv @@
module ght_cell #(
	parameter int IW  = 6,
	parameter int IDX = 0
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [ght_pkg::HANDLE_W-1:0]  id,
	input  ght_pkg::wr_t                  cmd,
	input  logic                          sel,
	input  logic                          free_i,
	input  logic [IW-1:0]                 free_slot_i,
	input  logic                          match_i,
	input  logic [IW-1:0]                 match_slot_i,
	input  logic [ght_pkg::TAG_W-1:0]     match_tag_i,
	input  logic                          dir_i,
	input  logic [ght_pkg::TAG_W-1:0]     dir_tag_i,
	output logic                          free_o,
	output logic [IW-1:0]                 free_slot_o,
	output logic                          match_o,
	output logic [IW-1:0]                 match_slot_o,
	output logic [ght_pkg::TAG_W-1:0]     match_tag_o,
	output logic                          dir_o,
	output logic [ght_pkg::TAG_W-1:0]     dir_tag_o
);

	logic                         valid_q;
	logic [ght_pkg::HANDLE_W-1:0] handle_q;
	logic [ght_pkg::TAG_W-1:0]    tag_q;
	logic                         hit;
	logic                         direct;

	assign hit    = valid_q && (handle_q == id);
	assign direct = hit && (id[ght_pkg::DIRECT_W-1:0] == ght_pkg::DIRECT_W'(IDX));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.clr_all) begin
			valid_q <= 1'b0;
		end else if (sel && cmd.wr) begin
			valid_q <= 1'b1;
		end else if (sel && cmd.clr_one) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (sel && cmd.wr) begin
			handle_q <= cmd.handle;
			tag_q    <= cmd.tag;
		end
	end

	// Search carry: first hit seen so far wins, so lower slots take priority.
	always_ff @(posedge clk) begin
		free_o       <= free_i || !valid_q;
		free_slot_o  <= free_i ? free_slot_i : IW'(IDX);
		match_o      <= match_i || hit;
		match_slot_o <= match_i ? match_slot_i : IW'(IDX);
		match_tag_o  <= match_i ? match_tag_i : tag_q;
		dir_o        <= dir_i || direct;
		dir_tag_o    <= direct ? tag_q : dir_tag_i;
	end

endmodule
